// ===== design/assert_macros.svh =====
// Assertion macros shared by the matcher RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GPM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define GPM_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define GPM_ASSERT(lbl, clk, rst, prop)
`define GPM_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== design/gpm_pkg.sv =====
// Types and constants of the greedy point matcher
`timescale 1ns / 1ps
package gpm_pkg;
   localparam int OUT_MAX = 16;
   localparam logic [31:0] WITHIN_RESET = 32'd640000;

   typedef enum logic [1:0] {
      OP_LOAD_LIGHT = 2'd0,
      OP_LOAD_VERT  = 2'd1,
      OP_RUN        = 2'd2,
      OP_CLEAR      = 2'd3
   } opcode_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_KEEP_P, ST_KL_RD, ST_KL_CHK, ST_KV_RD, ST_KV_CHK,
      ST_KD_W1, ST_KD_W2, ST_KD_CMP, ST_PRED_RD, ST_PRED_CHK,
      ST_MV_RD, ST_MV_CAP, ST_ML_RD, ST_ML_CHK, ST_MW1, ST_MW2, ST_MWR,
      ST_PK_INIT, ST_PK_RD, ST_PK_CHK, ST_PK_END, ST_PK_ID_RD, ST_PK_ID_CHK,
      ST_RPT, ST_FIN_ACK
   } state_type;

   typedef struct packed {
      logic [7:0]         id;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               pred;
   } light_entry_type;

   typedef struct packed {
      logic [3:0]         idx;
      logic signed [15:0] x;
      logic signed [15:0] y;
   } vertex_entry_type;

   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] bx;
      logic signed [15:0] by;
   } dist_operand_type;
endpackage

// ===== design/gpm_req_if.sv =====
// Request channel interface of the matcher
`timescale 1ns / 1ps
interface gpm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [7:0]         point_id;
   logic [3:0]         vertex_index;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic               is_prediction;

   modport source (output valid, opcode, point_id, vertex_index, pos_x, pos_y,
                   is_prediction, input ready);
   modport sink (input valid, opcode, point_id, vertex_index, pos_x, pos_y,
                 is_prediction, output ready);
endinterface

// ===== design/gpm_rsp_if.sv =====
// Response channel interface of the matcher
`timescale 1ns / 1ps
interface gpm_rsp_if;
   logic       valid;
   logic       ready;
   logic       pair_valid;
   logic [7:0] light_id;
   logic [3:0] paired_vertex;
   logic       newly_added;
   logic       tracking;
   logic       last;

   modport source (output valid, pair_valid, light_id, paired_vertex, newly_added,
                   tracking, last, input ready);
   modport sink (input valid, pair_valid, light_id, paired_vertex, newly_added,
                 tracking, last, output ready);
endinterface

// ===== design/gpm_ram.sv =====
// Simple dual-port synchronous RAM with registered read
`timescale 1ns / 1ps
module gpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/gpm_dist.sv =====
// Two-stage squared distance unit
`timescale 1ns / 1ps
module gpm_dist
   import gpm_pkg::*;
(
   input  logic             clock,
   input  dist_operand_type opnd,
   output logic [32:0]      dist_sq
);
   logic signed [16:0] dx, dy, ndx, ndy;
   logic [15:0] adx_in, ady_in, adx_ff, ady_ff;
   logic [31:0] sqx_ff, sqy_ff;

   always_comb begin
      dx = 17'(opnd.ax) - 17'(opnd.bx);
      dy = 17'(opnd.ay) - 17'(opnd.by);
      ndx = -dx;
      ndy = -dy;
      adx_in = dx[16] ? ndx[15:0] : dx[15:0];
      ady_in = dy[16] ? ndy[15:0] : dy[15:0];
   end

   always_ff @(posedge clock) begin
      adx_ff <= adx_in;
      ady_ff <= ady_in;
      sqx_ff <= adx_ff * adx_ff;
      sqy_ff <= ady_ff * ady_ff;
   end

   assign dist_sq = {1'b0, sqx_ff} + {1'b0, sqy_ff};
endmodule

// ===== design/greedy_point_matcher.sv =====
// Top level of the greedy point matcher
//
//  channel | dir | handshake         | payload
//  req_ch  | in  | valid/ready       | opcode, point_id, vertex_index, pos, is_prediction
//  rsp_ch  | out | valid/ready       | pair_valid, light_id, paired_vertex, flags, last
//  csr     | in  | csr_we            | csr_wdata (within_dist_sq)
//
// Loads, clear and an empty run are taken in the idle state and give one response each.
// A run reads the point, vertex and distance memories through a single read port each.
// Reset is synchronous; counts, pair valid bits and tracking clear at once.
// A stalled response holds the sequencer only where it emits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module greedy_point_matcher
   import gpm_pkg::*;
#(
   parameter int LIGHT_MAX = 16,
   parameter int VERT_MAX  = 16,
   parameter int PAIR_MAX  = 16
) (
   input  logic        clock,
   input  logic        reset,
   gpm_req_if.sink     req_ch,
   gpm_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   localparam int LW  = (LIGHT_MAX > 1) ? $clog2(LIGHT_MAX) : 1;
   localparam int VW  = (VERT_MAX > 1) ? $clog2(VERT_MAX) : 1;
   localparam int PW  = (PAIR_MAX > 1) ? $clog2(PAIR_MAX) : 1;
   localparam int LCW = $clog2(LIGHT_MAX + 1);
   localparam int VCW = $clog2(VERT_MAX + 1);
   localparam int MW  = LW + VW;
   localparam int NW  = $clog2(OUT_MAX);

   state_type state_ff, state_in;
   logic [LCW-1:0] light_cnt_ff;
   logic [VCW-1:0] vert_cnt_ff;
   logic [31:0] within_ff;
   logic tracking_ff;
   logic [PAIR_MAX-1:0] pv_ff, fresh_ff;
   logic [7:0] plid_ff [PAIR_MAX];
   logic [3:0] pvx_ff [PAIR_MAX];
   logic [LIGHT_MAX-1:0] lused_ff;
   logic [VERT_MAX-1:0] vused_ff;
   logic [PW-1:0] p_ff, free_slot;
   logic [LW-1:0] l_ff, fl_ff, bl_ff;
   logic [VW-1:0] v_ff, fv_ff, bv_ff;
   logic [32:0] best_ff, dist_sq, mat_rd;
   logic found_ff;
   logic [NW-1:0] n_ff;
   logic signed [15:0] lx_ff, ly_ff, vx_ff, vy_ff;

   logic rsp_valid_ff, rsp_pair_ff, rsp_fresh_ff, rsp_track_ff, rsp_last_ff;
   logic [7:0] rsp_lid_ff;
   logic [3:0] rsp_vtx_ff;

   light_entry_type lrd, lwr;
   vertex_entry_type vrd, vwr;
   dist_operand_type opnd;

   logic req_accept, run_start, can_emit, l_last, v_last, p_last, pk_end;
   logic l_hit, v_hit, pk_skip, dup, has_free, higher_valid, rpt_last, too_far;
   logic light_we, vert_we, mat_we;
   logic emit, e_pair, e_fresh, e_track, e_last;
   logic [7:0] e_lid;
   logic [3:0] e_vtx;

   assign can_emit   = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && can_emit;
   assign req_accept = req_ch.valid && req_ch.ready;
   assign run_start  = req_accept && req_ch.opcode == OP_RUN &&
                       light_cnt_ff != '0 && vert_cnt_ff != '0;

   assign l_last = (LCW'(l_ff) + LCW'(1)) == light_cnt_ff;
   assign v_last = (VCW'(v_ff) + VCW'(1)) == vert_cnt_ff;
   assign p_last = p_ff == PW'(PAIR_MAX - 1);
   assign pk_end = l_last && v_last;
   assign l_hit  = !lused_ff[l_ff] && (lrd.id == plid_ff[p_ff]);
   assign v_hit  = !vused_ff[v_ff] && (vrd.idx == pvx_ff[p_ff]);
   assign pk_skip = lused_ff[l_ff] || vused_ff[v_ff];
   assign too_far = dist_sq > {1'b0, within_ff};
   assign rpt_last = !higher_valid || (n_ff == NW'(OUT_MAX - 1));

   always_comb begin
      dup = 1'b0;
      has_free = 1'b0;
      free_slot = '0;
      higher_valid = 1'b0;
      for (int i = PAIR_MAX - 1; i >= 0; i--) begin
         if (pv_ff[i] && plid_ff[i] == lrd.id && pvx_ff[i] == vrd.idx) dup = 1'b1;
         if (!pv_ff[i]) begin
            has_free = 1'b1;
            free_slot = PW'(i);
         end
         if (pv_ff[i] && PW'(i) > p_ff) higher_valid = 1'b1;
      end
   end

   assign lwr = '{id: req_ch.point_id, x: req_ch.pos_x, y: req_ch.pos_y,
                  pred: req_ch.is_prediction};
   assign vwr = '{idx: req_ch.vertex_index, x: req_ch.pos_x, y: req_ch.pos_y};
   assign opnd = '{ax: lx_ff, ay: ly_ff, bx: vx_ff, by: vy_ff};

   gpm_ram #(.WIDTH($bits(light_entry_type)), .DEPTH(LIGHT_MAX), .AW(LW)) u_light (
      .clock(clock), .wr_en(light_we), .wr_addr(light_cnt_ff[LW-1:0]),
      .wr_data(lwr), .rd_addr(l_ff), .rd_data(lrd));

   gpm_ram #(.WIDTH($bits(vertex_entry_type)), .DEPTH(VERT_MAX), .AW(VW)) u_vert (
      .clock(clock), .wr_en(vert_we), .wr_addr(vert_cnt_ff[VW-1:0]),
      .wr_data(vwr), .rd_addr(v_ff), .rd_data(vrd));

   gpm_ram #(.WIDTH(33), .DEPTH(2 ** MW), .AW(MW)) u_matrix (
      .clock(clock), .wr_en(mat_we), .wr_addr({v_ff, l_ff}),
      .wr_data(dist_sq), .rd_addr({v_ff, l_ff}), .rd_data(mat_rd));

   gpm_dist u_dist (.clock(clock), .opnd(opnd), .dist_sq(dist_sq));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (run_start) state_in = ST_KEEP_P;
         end
         ST_KEEP_P: begin
            if (pv_ff[p_ff]) state_in = ST_KL_RD;
            else if (p_last) state_in = ST_PRED_RD;
         end
         ST_KL_RD: state_in = ST_KL_CHK;
         ST_KL_CHK: begin
            if (l_hit) state_in = ST_KV_RD;
            else if (l_last) state_in = p_last ? ST_PRED_RD : ST_KEEP_P;
            else state_in = ST_KL_RD;
         end
         ST_KV_RD: state_in = ST_KV_CHK;
         ST_KV_CHK: begin
            if (v_hit) state_in = ST_KD_W1;
            else if (v_last) state_in = p_last ? ST_PRED_RD : ST_KEEP_P;
            else state_in = ST_KV_RD;
         end
         ST_KD_W1: state_in = ST_KD_W2;
         ST_KD_W2: state_in = ST_KD_CMP;
         ST_KD_CMP: state_in = p_last ? ST_PRED_RD : ST_KEEP_P;
         ST_PRED_RD: state_in = ST_PRED_CHK;
         ST_PRED_CHK: state_in = l_last ? ST_MV_RD : ST_PRED_RD;
         ST_MV_RD: state_in = ST_MV_CAP;
         ST_MV_CAP: state_in = ST_ML_RD;
         ST_ML_RD: state_in = ST_ML_CHK;
         ST_ML_CHK: state_in = ST_MW1;
         ST_MW1: state_in = ST_MW2;
         ST_MW2: state_in = ST_MWR;
         ST_MWR: begin
            if (!l_last) state_in = ST_ML_RD;
            else state_in = v_last ? ST_PK_INIT : ST_MV_RD;
         end
         ST_PK_INIT: state_in = ST_PK_RD;
         ST_PK_RD: begin
            if (!pk_skip) state_in = ST_PK_CHK;
            else if (pk_end) state_in = ST_PK_END;
         end
         ST_PK_CHK: state_in = pk_end ? ST_PK_END : ST_PK_RD;
         ST_PK_END: state_in = found_ff ? ST_PK_ID_RD : ST_RPT;
         ST_PK_ID_RD: state_in = ST_PK_ID_CHK;
         ST_PK_ID_CHK: state_in = (dup || has_free) ? ST_PK_INIT : ST_RPT;
         ST_RPT: begin
            if (pv_ff[p_ff]) begin
               if (can_emit && rpt_last) state_in = ST_IDLE;
            end else if (p_last) begin
               state_in = ST_FIN_ACK;
            end
         end
         ST_FIN_ACK: if (can_emit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      emit = 1'b0;
      e_pair = 1'b0;
      e_lid = '0;
      e_vtx = '0;
      e_fresh = 1'b0;
      e_track = tracking_ff;
      e_last = 1'b1;
      light_we = 1'b0;
      vert_we = 1'b0;
      mat_we = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            emit = req_accept && !run_start;
            if (req_ch.opcode == OP_CLEAR) e_track = 1'b0;
            light_we = req_accept && req_ch.opcode == OP_LOAD_LIGHT &&
                       light_cnt_ff < LCW'(LIGHT_MAX);
            vert_we = req_accept && req_ch.opcode == OP_LOAD_VERT &&
                      vert_cnt_ff < VCW'(VERT_MAX);
         end
         ST_MWR: mat_we = 1'b1;
         ST_RPT: begin
            emit = pv_ff[p_ff] && can_emit;
            e_pair = 1'b1;
            e_lid = plid_ff[p_ff];
            e_vtx = pvx_ff[p_ff];
            e_fresh = fresh_ff[p_ff];
            e_track = 1'b1;
            e_last = rpt_last;
         end
         ST_FIN_ACK: begin
            emit = can_emit;
            e_track = 1'b1;
         end
         default: emit = 1'b0;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         light_cnt_ff <= '0;
         vert_cnt_ff <= '0;
         pv_ff <= '0;
         tracking_ff <= 1'b0;
         within_ff <= WITHIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) within_ff <= csr_wdata;
         rsp_valid_ff <= emit || (rsp_valid_ff && !rsp_ch.ready);
         if (light_we) light_cnt_ff <= light_cnt_ff + LCW'(1);
         if (vert_we) vert_cnt_ff <= vert_cnt_ff + VCW'(1);
         if (state_ff == ST_IDLE && req_accept && req_ch.opcode == OP_CLEAR) begin
            pv_ff <= '0;
            tracking_ff <= 1'b0;
         end
         if ((state_ff == ST_KL_CHK && !l_hit && l_last) ||
             (state_ff == ST_KV_CHK && !v_hit && v_last) ||
             (state_ff == ST_KD_CMP && too_far)) pv_ff[p_ff] <= 1'b0;
         if (state_ff == ST_PK_ID_CHK && !dup && has_free) pv_ff[free_slot] <= 1'b1;
         if (state_in == ST_RPT && state_ff != ST_RPT) begin
            tracking_ff <= 1'b1;
            light_cnt_ff <= '0;
            vert_cnt_ff <= '0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_pair_ff <= e_pair;
         rsp_lid_ff <= e_lid;
         rsp_vtx_ff <= e_vtx;
         rsp_fresh_ff <= e_fresh;
         rsp_track_ff <= e_track;
         rsp_last_ff <= e_last;
      end
      if (state_in == ST_RPT && state_ff != ST_RPT) begin
         p_ff <= '0;
         n_ff <= '0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            p_ff <= '0;
            lused_ff <= '0;
            vused_ff <= '0;
            fresh_ff <= '0;
         end
         ST_KEEP_P: begin
            l_ff <= '0;
            if (!pv_ff[p_ff]) p_ff <= p_ff + PW'(1);
         end
         ST_KL_CHK: begin
            if (l_hit) begin
               fl_ff <= l_ff;
               lx_ff <= lrd.x;
               ly_ff <= lrd.y;
               v_ff <= '0;
            end else if (l_last) begin
               p_ff <= p_ff + PW'(1);
               l_ff <= '0;
            end else begin
               l_ff <= l_ff + LW'(1);
            end
         end
         ST_KV_CHK: begin
            if (v_hit) begin
               fv_ff <= v_ff;
               vx_ff <= vrd.x;
               vy_ff <= vrd.y;
            end else if (v_last) begin
               p_ff <= p_ff + PW'(1);
               l_ff <= '0;
            end else begin
               v_ff <= v_ff + VW'(1);
            end
         end
         ST_KD_CMP: begin
            if (!too_far) begin
               lused_ff[fl_ff] <= 1'b1;
               vused_ff[fv_ff] <= 1'b1;
            end
            p_ff <= p_ff + PW'(1);
            l_ff <= '0;
         end
         ST_PRED_CHK: begin
            if (lrd.pred) lused_ff[l_ff] <= 1'b1;
            if (l_last) begin
               l_ff <= '0;
               v_ff <= '0;
            end else begin
               l_ff <= l_ff + LW'(1);
            end
         end
         ST_MV_CAP: begin
            vx_ff <= vrd.x;
            vy_ff <= vrd.y;
            l_ff <= '0;
         end
         ST_ML_CHK: begin
            lx_ff <= lrd.x;
            ly_ff <= lrd.y;
         end
         ST_MWR: begin
            if (l_last) begin
               l_ff <= '0;
               v_ff <= v_ff + VW'(1);
            end else begin
               l_ff <= l_ff + LW'(1);
            end
         end
         ST_PK_INIT: begin
            best_ff <= {1'b0, within_ff};
            found_ff <= 1'b0;
            l_ff <= '0;
            v_ff <= '0;
         end
         ST_PK_RD, ST_PK_CHK: begin
            if (state_ff == ST_PK_CHK && mat_rd < best_ff) begin
               best_ff <= mat_rd;
               bl_ff <= l_ff;
               bv_ff <= v_ff;
               found_ff <= 1'b1;
            end
            if (state_ff == ST_PK_CHK || pk_skip) begin
               if (l_last) begin
                  l_ff <= '0;
                  v_ff <= v_ff + VW'(1);
               end else begin
                  l_ff <= l_ff + LW'(1);
               end
            end
         end
         ST_PK_END: begin
            if (found_ff) begin
               lused_ff[bl_ff] <= 1'b1;
               vused_ff[bv_ff] <= 1'b1;
               l_ff <= bl_ff;
               v_ff <= bv_ff;
            end
         end
         ST_PK_ID_CHK: begin
            if (!dup && has_free) begin
               plid_ff[free_slot] <= lrd.id;
               pvx_ff[free_slot] <= vrd.idx;
               fresh_ff[free_slot] <= 1'b1;
            end
         end
         ST_RPT: begin
            if (!pv_ff[p_ff]) begin
               p_ff <= p_ff + PW'(1);
            end else if (can_emit) begin
               p_ff <= p_ff + PW'(1);
               n_ff <= n_ff + NW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.pair_valid = rsp_pair_ff;
   assign rsp_ch.light_id = rsp_lid_ff;
   assign rsp_ch.paired_vertex = rsp_vtx_ff;
   assign rsp_ch.newly_added = rsp_fresh_ff;
   assign rsp_ch.tracking = rsp_track_ff;
   assign rsp_ch.last = rsp_last_ff;

   `GPM_ASSERT(a_ready_idle, clock, reset, req_ch.ready |-> state_ff == ST_IDLE)
   `GPM_NEVER(a_light_cnt, clock, reset, light_cnt_ff > LCW'(LIGHT_MAX))
   `GPM_ASSERT(a_rpt_tracking, clock, reset, state_ff == ST_RPT |-> tracking_ff)
   `GPM_ASSERT(a_emit_room, clock, reset, emit |-> can_emit)
endmodule

// ===== test/tb.sv =====
// Testbench for the greedy point matcher: table-driven directed items, then random frames
`timescale 1ns / 1ps
module tb;
   import gpm_pkg::*;

   typedef struct packed {
      logic       pair_valid;
      logic [7:0] light_id;
      logic [3:0] paired_vertex;
      logic       newly_added;
      logic       tracking;
      logic       last;
   } pairing_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [7:0]         point_id;
      logic [3:0]         vertex_index;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic               is_prediction;
   } request_type;

   typedef struct {
      request_type req;
      logic        has_expected;
      pairing_type expected;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [31:0] csr_wdata;
   gpm_req_if   req_ch ();
   gpm_rsp_if   rsp_ch ();

   greedy_point_matcher DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   light_entry_type  lights [16];
   int               n_lights;
   vertex_entry_type verts [16];
   int               n_verts;
   logic             pair_ok [16];
   logic [7:0]       pair_lid [16];
   logic [3:0]       pair_vtx [16];
   logic             track_flag;
   logic [31:0]      limit_sq;

   pairing_type      pairing_queue [$];
   pairing_type      typed_queue [$];
   int               errors;
   logic             quiet;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #80ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [63:0] span_sq(logic signed [15:0] ax, logic signed [15:0] ay,
                                           logic signed [15:0] bx, logic signed [15:0] by);
      longint dx, dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      return dx * dx + dy * dy;
   endfunction

   function automatic pairing_type ack_of();
      pairing_type r;
      r = '0;
      r.tracking = track_flag;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic predict_match(input request_type rq);
      logic lused [16];
      logic vused [16];
      logic fresh [16];
      int fl, fv, bl, bv, slot, n;
      logic [63:0] best, d;
      logic dup;
      pairing_type r;
      unique case (opcode_type'(rq.opcode))
         OP_LOAD_LIGHT: begin
            if (n_lights < 16) begin
               lights[n_lights] = '{rq.point_id, rq.pos_x, rq.pos_y, rq.is_prediction};
               n_lights++;
            end
            pairing_queue = {pairing_queue, ack_of()};
         end
         OP_LOAD_VERT: begin
            if (n_verts < 16) begin
               verts[n_verts] = '{rq.vertex_index, rq.pos_x, rq.pos_y};
               n_verts++;
            end
            pairing_queue = {pairing_queue, ack_of()};
         end
         OP_CLEAR: begin
            foreach (pair_ok[p]) pair_ok[p] = 1'b0;
            track_flag = 1'b0;
            pairing_queue = {pairing_queue, ack_of()};
         end
         default: begin
            if (n_lights == 0 || n_verts == 0) begin
               pairing_queue = {pairing_queue, ack_of()};
               return;
            end
            for (int i = 0; i < 16; i++) begin
               lused[i] = 1'b0; vused[i] = 1'b0; fresh[i] = 1'b0;
            end
            for (int p = 0; p < 16; p++) begin
               if (!pair_ok[p]) continue;
               fl = -1; fv = -1;
               for (int l = 0; l < n_lights; l++)
                  if (fl < 0 && !lused[l] && lights[l].id == pair_lid[p]) fl = l;
               for (int v = 0; v < n_verts; v++)
                  if (fv < 0 && !vused[v] && verts[v].idx == pair_vtx[p]) fv = v;
               if (fl < 0 || fv < 0 || span_sq(lights[fl].x, lights[fl].y,
                     verts[fv].x, verts[fv].y) > {32'd0, limit_sq})
                  pair_ok[p] = 1'b0;
               else begin
                  lused[fl] = 1'b1; vused[fv] = 1'b1;
               end
            end
            for (int l = 0; l < n_lights; l++) if (lights[l].pred) lused[l] = 1'b1;
            forever begin
               bl = -1; bv = -1; slot = -1; dup = 1'b0;
               best = {32'd0, limit_sq};
               for (int v = 0; v < n_verts; v++) begin
                  if (vused[v]) continue;
                  for (int l = 0; l < n_lights; l++) begin
                     if (lused[l]) continue;
                     d = span_sq(lights[l].x, lights[l].y, verts[v].x, verts[v].y);
                     if (d < best) begin
                        best = d; bl = l; bv = v;
                     end
                  end
               end
               if (bl < 0) break;
               lused[bl] = 1'b1; vused[bv] = 1'b1;
               for (int p = 0; p < 16; p++) begin
                  if (pair_ok[p]) begin
                     if (pair_lid[p] == lights[bl].id && pair_vtx[p] == verts[bv].idx)
                        dup = 1'b1;
                  end else if (slot < 0) slot = p;
               end
               if (dup) continue;
               if (slot < 0) break;
               pair_ok[slot] = 1'b1;
               pair_lid[slot] = lights[bl].id;
               pair_vtx[slot] = verts[bv].idx;
               fresh[slot] = 1'b1;
            end
            track_flag = 1'b1;
            n_lights = 0;
            n_verts = 0;
            n = 0;
            for (int p = 0; p < 16; p++) begin
               if (!pair_ok[p]) continue;
               r = '{1'b1, pair_lid[p], pair_vtx[p], fresh[p], 1'b1, 1'b0};
               pairing_queue = {pairing_queue, r};
               n++;
            end
            if (n == 0) pairing_queue = {pairing_queue, ack_of()};
            else pairing_queue[$].last = 1'b1;
         end
      endcase
   endtask

   // response side
   initial begin
      pairing_type got, want;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready && !reset) begin
            got = '{rsp_ch.pair_valid, rsp_ch.light_id, rsp_ch.paired_vertex,
                    rsp_ch.newly_added, rsp_ch.tracking, rsp_ch.last};
            if (pairing_queue.size() == 0) begin
               $error("unexpected transfer %p", got);
               errors++;
            end else begin
               want = pairing_queue.pop_front();
               if (typed_queue.size() > 0) begin
                  if (typed_queue[0] != want) begin
                     $error("table row %p disagrees with prediction %p", typed_queue[0], want);
                     errors++;
                  end
                  void'(typed_queue.pop_front());
               end
               if (got.pair_valid != want.pair_valid) begin
                  $error("pair_valid expected %0d actual %0d", want.pair_valid, got.pair_valid);
                  errors++;
               end
               if (got.light_id != want.light_id) begin
                  $error("light_id expected %0d actual %0d", want.light_id, got.light_id);
                  errors++;
               end
               if (got.paired_vertex != want.paired_vertex) begin
                  $error("paired_vertex expected %0d actual %0d",
                         want.paired_vertex, got.paired_vertex);
                  errors++;
               end
               if (got.newly_added != want.newly_added) begin
                  $error("newly_added expected %0d actual %0d",
                         want.newly_added, got.newly_added);
                  errors++;
               end
               if (got.tracking != want.tracking) begin
                  $error("tracking expected %0d actual %0d", want.tracking, got.tracking);
                  errors++;
               end
               if (got.last != want.last) begin
                  $error("last expected %0d actual %0d", want.last, got.last);
                  errors++;
               end
            end
         end
         rsp_ch.ready <= reset ? 1'b0 : (quiet ? 1'b1 : ($urandom_range(99) >= 6));
      end
   end

   task automatic send(input request_type rq);
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= rq.opcode;
      req_ch.point_id     <= rq.point_id;
      req_ch.vertex_index <= rq.vertex_index;
      req_ch.pos_x        <= rq.pos_x;
      req_ch.pos_y        <= rq.pos_y;
      req_ch.is_prediction <= rq.is_prediction;
      do @(posedge clock); while (!req_ch.ready);
      predict_match(rq);
      if (!quiet && $urandom_range(99) < 6) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pairing_queue.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      limit_sq = value;
   endtask

   function automatic request_type mk(logic [1:0] op, int id, int vi, int x, int y, int pr);
      request_type rq;
      rq = '{op, 8'(id), 4'(vi), 16'(x), 16'(y), 1'(pr)};
      return rq;
   endfunction

   function automatic request_type rand_near(logic [1:0] op, int spread);
      request_type rq;
      rq = mk(op, $urandom_range(7), $urandom_range(7),
              $urandom_range(2 * spread) - spread,
              $urandom_range(2 * spread) - spread, int'($urandom_range(99) < 15));
      return rq;
   endfunction

   directed_row_type rows [$];
   pairing_type      ak0, ak1;

   initial begin
      request_type rq;
      int k, nl, nv;
      errors = 0;
      quiet = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_LOAD_LIGHT;
      req_ch.point_id = '0;
      req_ch.vertex_index = '0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.is_prediction = 1'b0;
      n_lights = 0; n_verts = 0; track_flag = 1'b0; limit_sq = WITHIN_RESET;
      foreach (pair_ok[p]) pair_ok[p] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      ak0 = '{1'b0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b1};
      ak1 = '{1'b0, 8'd0, 4'd0, 1'b0, 1'b1, 1'b1};
      rows = '{
         '{mk(OP_RUN, 0, 0, 0, 0, 0), 1'b1, ak0},
         '{mk(OP_LOAD_LIGHT, 'hFF, 0, 'h7FFF, 'h8000, 1), 1'b1, ak0},
         '{mk(OP_RUN, 0, 0, 0, 0, 0), 1'b1, ak0},
         '{mk(OP_LOAD_VERT, 0, 'hF, 'h8000, 'h7FFF, 0), 1'b1, ak0},
         '{mk(OP_LOAD_LIGHT, 'h00, 0, 'h8000, 'h7FFF, 0), 1'b1, ak0},
         '{mk(OP_LOAD_LIGHT, 'h01, 0, 'h8000, 'h7FFF, 0), 1'b1, ak0},
         '{mk(OP_RUN, 0, 0, 0, 0, 0), 1'b0, ak0},
         '{mk(OP_LOAD_LIGHT, 'h00, 0, 'h8010, 'h7FFF, 0), 1'b1, ak1},
         '{mk(OP_LOAD_VERT, 0, 'hF, 'h8000, 'h7FFF, 0), 1'b1, ak1},
         '{mk(OP_LOAD_VERT, 0, 'h3, 'h8020, 'h7FFF, 0), 1'b1, ak1},
         '{mk(OP_LOAD_LIGHT, 'hAA, 0, 'h8020, 'h7FF0, 0), 1'b1, ak1},
         '{mk(OP_RUN, 0, 0, 0, 0, 0), 1'b0, ak1},
         '{mk(OP_CLEAR, 0, 0, 0, 0, 0), 1'b1, ak0},
         '{mk(OP_LOAD_LIGHT, 'h05, 0, 'h7FFF, 'h7FFF, 0), 1'b1, ak0},
         '{mk(OP_LOAD_VERT, 0, 'h5, 'h8000, 'h8000, 0), 1'b1, ak0},
         '{mk(OP_RUN, 0, 0, 0, 0, 0), 1'b0, ak0}
      };
      foreach (rows[i]) begin
         if (rows[i].has_expected) typed_queue = {typed_queue, rows[i].expected};
         send(rows[i].req);
         if (!rows[i].has_expected) begin
            drain();
            typed_queue.delete();
         end
      end

      // widest limit: far points pair, with an overfull store and a full pair table; then a zero limit
      write_limit(32'hFFFF_FFFF);
      for (int i = 0; i < 18; i++) send(mk(OP_LOAD_LIGHT, i, 0, $urandom, $urandom, 0));
      for (int i = 0; i < 18; i++) send(mk(OP_LOAD_VERT, 0, i, $urandom, $urandom, 0));
      send(mk(OP_RUN, 0, 0, 0, 0, 0));
      for (int i = 0; i < 16; i++) send(mk(OP_LOAD_LIGHT, i + 100, 0, 0, 0, 0));
      for (int i = 0; i < 4; i++) send(mk(OP_LOAD_VERT, 0, i, 0, 0, 0));
      send(mk(OP_RUN, 0, 0, 0, 0, 0));
      write_limit(32'd0);
      send(mk(OP_LOAD_LIGHT, 1, 0, 0, 0, 0));
      send(mk(OP_LOAD_VERT, 0, 1, 0, 0, 0));
      send(mk(OP_RUN, 0, 0, 0, 0, 0));
      send(mk(OP_CLEAR, 0, 0, 0, 0, 0));

      // random frames, most well formed and small
      k = 0;
      while (k < 30) begin
         case ($urandom_range(3))
            0: write_limit(32'd640000);
            1: write_limit($urandom_range(4096, 0));
            2: write_limit($urandom);
            default: ;
         endcase
         quiet = (k >= 6 && k < 22);
         nl = $urandom_range(5);
         nv = $urandom_range(5);
         repeat (nl + nv) begin
            if ($urandom_range(99) < 5)
               rq = mk(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if ($urandom_range(1)) rq = rand_near(OP_LOAD_LIGHT, 1200);
            else rq = rand_near(OP_LOAD_VERT, 1200);
            if ($urandom_range(99) < 10) begin
               rq.pos_x = 16'($urandom); rq.pos_y = 16'($urandom);
               rq.point_id = 8'($urandom);
               rq.vertex_index = 4'($urandom);
            end
            send(rq);
            k++;
         end
         send(mk(OP_RUN, $urandom, $urandom, $urandom, $urandom, $urandom));
         k++;
         if ($urandom_range(5) == 0) drain();
      end
      quiet = 1'b0;
      drain();
      repeat (200) @(posedge clock);
      if (errors == 0 && pairing_queue.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
